// ===== hw/rtl/nearest_upsample_relu_assert.svh =====
// assertion macros for the nearest-neighbor upsampler
// expects a clock named clk and a synchronous reset named rst in the using scope
`ifndef NEAREST_UPSAMPLE_RELU_ASSERT_SVH
`define NEAREST_UPSAMPLE_RELU_ASSERT_SVH

// same-cycle implication
`define NUR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NUR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// delayed implication
`define NUR_ASSERT_THREE(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##3 (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/nur_pkg.sv =====
// shared types and constants for the nearest-neighbor upsampler
// no dependencies
`timescale 1ns / 1ps

package nur_pkg;

  // field widths
  localparam int VALUE_W    = 16;
  localparam int COORD_W    = 15;
  localparam int DIM_CFG_W  = 13;
  localparam int FACTOR_W   = 4;
  localparam int CAP_W      = 15;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 3;

  // parameter defaults
  localparam int MAX_DIM_DEF    = 4096;
  localparam int MAX_FACTOR_DEF = 8;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_WIDTH    = 3'd0,
    REG_IN_HEIGHT   = 3'd1,
    REG_FACTOR_ROWS = 3'd2,
    REG_FACTOR_COLS = 3'd3,
    REG_RELU_ENABLE = 3'd4,
    REG_RELU_CAP    = 3'd5
  } reg_idx_t;

  // configuration registers
  typedef struct packed {
    logic [DIM_CFG_W-1:0] in_width;
    logic [DIM_CFG_W-1:0] in_height;
    logic [FACTOR_W-1:0]  factor_rows;
    logic [FACTOR_W-1:0]  factor_cols;
    logic                 relu_enable;
    logic [CAP_W-1:0]     relu_cap;
  } cfg_t;

  // one classified pixel waiting for expansion
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [COORD_W-1:0]        base_row;
    logic [COORD_W-1:0]        base_col;
    logic [FACTOR_W-1:0]       fr;
    logic [FACTOR_W-1:0]       fc;
  } entry_t;

  // back end status
  typedef struct packed {
    logic busy;
  } back_status_t;

endpackage

// ===== hw/rtl/nur_if.sv =====
// valid/ready channels for input pixels and output copies
// depends on nur_pkg
`timescale 1ns / 1ps

interface nur_pixel_if;
  logic                               valid;
  logic                               ready;
  logic signed [nur_pkg::VALUE_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface nur_copy_if;
  logic                               valid;
  logic                               ready;
  logic signed [nur_pkg::VALUE_W-1:0] out_value;
  logic [nur_pkg::COORD_W-1:0]        out_row;
  logic [nur_pkg::COORD_W-1:0]        out_col;
  logic                               last_copy;

  modport source (output valid, output out_value, output out_row, output out_col,
                  output last_copy, input ready);
  modport sink (input valid, input out_value, input out_row, input out_col,
                input last_copy, output ready);
endinterface

// ===== hw/rtl/nur_front.sv =====
// front end: accepts pixels, rectifies, tracks raster position, builds queue entries
// depends on nur_pkg and nur_if
`timescale 1ns / 1ps

module nur_front #(
  parameter int MAX_DIM    = nur_pkg::MAX_DIM_DEF,
  parameter int MAX_FACTOR = nur_pkg::MAX_FACTOR_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nur_pkg::cfg_t        cfg,
  nur_pixel_if.sink            pixels,
  input  logic                 q_full,
  output logic                 q_push,
  output nur_pkg::entry_t      q_entry
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CMPW  = (DW > nur_pkg::DIM_CFG_W) ? DW : nur_pkg::DIM_CFG_W;
  localparam int FW    = nur_pkg::FACTOR_W;
  localparam int PW    = CNT_W + FW;

  logic [CNT_W-1:0] row_count, row_count_next;
  logic [CNT_W-1:0] col_count, col_count_next;
  logic [CMPW-1:0]  w_ext, h_ext, w_eff, h_eff;
  logic [CMPW-1:0]  col_inc, row_inc;
  logic [FW-1:0]    fr_eff, fc_eff;
  logic [PW-1:0]    prod_row, prod_col;
  logic signed [nur_pkg::VALUE_W-1:0] value_rect;
  logic signed [nur_pkg::VALUE_W-1:0] cap_s;
  logic             accept;

  assign pixels.ready = !q_full;
  assign accept       = pixels.valid && !q_full;
  assign q_push       = accept;

  // effective plane size: zero acts as one, oversize acts as the maximum
  always_comb begin
    w_ext = CMPW'(cfg.in_width);
    h_ext = CMPW'(cfg.in_height);
    if (w_ext == '0) begin
      w_eff = CMPW'(1);
    end else if (w_ext > CMPW'(MAX_DIM)) begin
      w_eff = CMPW'(MAX_DIM);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = CMPW'(1);
    end else if (h_ext > CMPW'(MAX_DIM)) begin
      h_eff = CMPW'(MAX_DIM);
    end else begin
      h_eff = h_ext;
    end
  end

  // effective replication factors
  always_comb begin
    if (cfg.factor_rows == '0) begin
      fr_eff = FW'(1);
    end else if (cfg.factor_rows > FW'(MAX_FACTOR)) begin
      fr_eff = FW'(MAX_FACTOR);
    end else begin
      fr_eff = cfg.factor_rows;
    end
    if (cfg.factor_cols == '0) begin
      fc_eff = FW'(1);
    end else if (cfg.factor_cols > FW'(MAX_FACTOR)) begin
      fc_eff = FW'(MAX_FACTOR);
    end else begin
      fc_eff = cfg.factor_cols;
    end
  end

  // optional rectification with cap
  always_comb begin
    cap_s      = nur_pkg::VALUE_W'(cfg.relu_cap);
    value_rect = pixels.pixel_value;
    if (cfg.relu_enable) begin
      if (pixels.pixel_value < 0) begin
        value_rect = '0;
      end else if (cfg.relu_cap != '0 && pixels.pixel_value > cap_s) begin
        value_rect = cap_s;
      end
    end
  end

  // output base coordinates
  assign prod_row = PW'(row_count) * PW'(fr_eff);
  assign prod_col = PW'(col_count) * PW'(fc_eff);

  always_comb begin
    q_entry.value    = value_rect;
    q_entry.base_row = nur_pkg::COORD_W'(prod_row);
    q_entry.base_col = nur_pkg::COORD_W'(prod_col);
    q_entry.fr       = fr_eff;
    q_entry.fc       = fc_eff;
  end

  // raster position, wraps when reached or passed
  always_comb begin
    col_inc        = CMPW'(col_count) + CMPW'(1);
    row_inc        = CMPW'(row_count) + CMPW'(1);
    col_count_next = CNT_W'(col_inc);
    row_count_next = row_count;
    if (col_inc >= w_eff) begin
      col_count_next = '0;
      if (row_inc >= h_eff) begin
        row_count_next = '0;
      end else begin
        row_count_next = CNT_W'(row_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

endmodule

// ===== hw/rtl/nur_queue.sv =====
// short entry queue between front and back ends
// depends on nur_pkg
`timescale 1ns / 1ps

module nur_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  nur_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output nur_pkg::entry_t pop_entry
);

  localparam int DEPTH = nur_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  nur_pkg::entry_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_entry = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/nur_back.sv =====
// back end: expands each entry into its copies, one word per cycle unless copies stalls
// depends on nur_pkg and nur_if
`timescale 1ns / 1ps

module nur_back #(
  parameter int MAX_FACTOR = nur_pkg::MAX_FACTOR_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_not_empty,
  input  nur_pkg::entry_t       q_entry,
  output logic                  q_pop,
  output nur_pkg::back_status_t status,
  nur_copy_if.source            copies
);

  localparam int CW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int FW = nur_pkg::FACTOR_W;

  nur_pkg::entry_t ent;
  logic            busy;
  logic [CW-1:0]   copy_row;
  logic [CW-1:0]   copy_col;
  logic            out_valid;
  logic            take;
  logic            row_end;
  logic            last_cur;

  // output register free or being drained
  assign take     = !out_valid || copies.ready;
  assign row_end  = (FW'(copy_col) == ent.fc - FW'(1));
  assign last_cur = row_end && (FW'(copy_row) == ent.fr - FW'(1));
  assign q_pop    = q_not_empty && (!busy || (take && last_cur));

  assign status.busy  = busy;
  assign copies.valid = out_valid;

  // entry register and copy counters
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (q_pop) begin
      busy <= 1'b1;
    end else if (busy && take && last_cur) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent      <= q_entry;
      copy_row <= '0;
      copy_col <= '0;
    end else if (busy && take && !last_cur) begin
      if (row_end) begin
        copy_col <= '0;
        copy_row <= copy_row + CW'(1);
      end else begin
        copy_col <= copy_col + CW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (take && busy) begin
      copies.out_value <= ent.value;
      copies.out_row   <= ent.base_row + nur_pkg::COORD_W'(copy_row);
      copies.out_col   <= ent.base_col + nur_pkg::COORD_W'(copy_col);
      copies.last_copy <= last_cur;
    end
  end

endmodule

// ===== hw/rtl/nearest_upsample_relu.sv =====
// top level of the nearest-neighbor upsampler with optional relu
// depends on nur_pkg, nur_if, nur_front, nur_queue, nur_back
//
//   channel   kind       handshake        payload
//   pixels    in         valid/ready      pixel_value
//   copies    out        valid/ready      out_value, out_row, out_col, last_copy
//   cfg       in         cfg_write        cfg_index, cfg_data
//
// copies leave at one per cycle from the back end output register while copies.ready is
// high, so a pixel yields factor_rows * factor_cols copies (4 for a 2x2 factor)
// first copy of a pixel accepted on an idle block passes the queue, entry and output registers
// a stalled copies channel fills the four-entry queue before pixels.ready drops
// rst is synchronous: counters cleared, registers back to their defaults
`timescale 1ns / 1ps
`include "nearest_upsample_relu_assert.svh"

module nearest_upsample_relu #(
  parameter int MAX_DIM    = nur_pkg::MAX_DIM_DEF,
  parameter int MAX_FACTOR = nur_pkg::MAX_FACTOR_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  nur_pixel_if.sink                      pixels,
  nur_copy_if.source                     copies,
  input  logic                           cfg_write,
  input  logic [nur_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nur_pkg::CFG_DATA_W-1:0] cfg_data
);

  nur_pkg::cfg_t         cfg;
  nur_pkg::entry_t       push_entry;
  nur_pkg::entry_t       pop_entry;
  nur_pkg::back_status_t be_status;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_not_empty;
  logic                  block_idle;
  logic                  idle_accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_width    <= nur_pkg::DIM_CFG_W'(1);
      cfg.in_height   <= nur_pkg::DIM_CFG_W'(1);
      cfg.factor_rows <= nur_pkg::FACTOR_W'(1);
      cfg.factor_cols <= nur_pkg::FACTOR_W'(1);
      cfg.relu_enable <= 1'b0;
      cfg.relu_cap    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        nur_pkg::REG_IN_WIDTH:    cfg.in_width    <= cfg_data[nur_pkg::DIM_CFG_W-1:0];
        nur_pkg::REG_IN_HEIGHT:   cfg.in_height   <= cfg_data[nur_pkg::DIM_CFG_W-1:0];
        nur_pkg::REG_FACTOR_ROWS: cfg.factor_rows <= cfg_data[nur_pkg::FACTOR_W-1:0];
        nur_pkg::REG_FACTOR_COLS: cfg.factor_cols <= cfg_data[nur_pkg::FACTOR_W-1:0];
        nur_pkg::REG_RELU_ENABLE: cfg.relu_enable <= cfg_data[0];
        nur_pkg::REG_RELU_CAP:    cfg.relu_cap    <= cfg_data[nur_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // front end
  nur_front #(
    .MAX_DIM    (MAX_DIM),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pixels  (pixels),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  // decoupling queue
  nur_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .pop_entry  (pop_entry)
  );

  // back end
  nur_back #(
    .MAX_FACTOR (MAX_FACTOR)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_entry     (pop_entry),
    .q_pop       (q_pop),
    .status      (be_status),
    .copies      (copies)
  );

  // nothing queued, expanding or waiting at the output
  assign block_idle  = !be_status.busy && !q_not_empty && !copies.valid;
  assign idle_accept = pixels.valid && pixels.ready && block_idle;

  // checks
  `NUR_ASSERT_NOW(a_full_blocks_input, q_full, !pixels.ready, "pixel taken while queue full")
  `NUR_ASSERT_NEXT(a_idle_stays_quiet, block_idle, !copies.valid, "copy with no work pending")
  `NUR_ASSERT_THREE(a_idle_pixel_latency, idle_accept, copies.valid, "first copy late")

endmodule

// ===== tb/nur_upsample_checker.sv =====
// scoreboard for the nearest-neighbor upsampler: predicts every output copy
// depends on nur_pkg and nur_if; watches the pixel, copy and register ports
`timescale 1ns / 1ps

module nur_upsample_checker
  import nur_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  nur_pixel_if                  pixels,
  nur_copy_if                   copies,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    outstanding
);

  localparam int REPORT_MAX = 30;

  // one output copy as it should leave the block
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [COORD_W-1:0]        row;
    logic [COORD_W-1:0]        col;
    logic                      last_copy;
  } copy_t;

  // shadow registers
  logic [DIM_CFG_W-1:0] width_reg;
  logic [DIM_CFG_W-1:0] height_reg;
  logic [FACTOR_W-1:0]  rows_factor_reg;
  logic [FACTOR_W-1:0]  cols_factor_reg;
  logic                 relu_on;
  logic [CAP_W-1:0]     cap_reg;

  // input raster position
  int unsigned row_pos;
  int unsigned col_pos;

  copy_t pending_copies[$];
  int    reports;

  // zero acts as one, oversized values saturate
  function automatic int unsigned effective(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // queue all copies of one pixel and advance the raster position
  function automatic void expand_pixel(logic signed [VALUE_W-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned fr;
    int unsigned fc;
    int          v;
    copy_t       c;
    w  = effective(width_reg, MAX_DIM_DEF);
    h  = effective(height_reg, MAX_DIM_DEF);
    fr = effective(rows_factor_reg, MAX_FACTOR_DEF);
    fc = effective(cols_factor_reg, MAX_FACTOR_DEF);
    v  = px;
    if (relu_on) begin
      if (v < 0) v = 0;
      if (cap_reg != 0 && v > int'(cap_reg)) v = int'(cap_reg);
    end
    for (int unsigned r = 0; r < fr; r++) begin
      for (int unsigned k = 0; k < fc; k++) begin
        c.value     = v[VALUE_W-1:0];
        c.row       = COORD_W'(row_pos * fr + r);
        c.col       = COORD_W'(col_pos * fc + k);
        c.last_copy = (r == fr - 1) && (k == fc - 1);
        pending_copies.push_back(c);
      end
    end
    // end test is reached or passed, so a shrunk plane still wraps
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
    row_pos &= 32'hFFF;
    col_pos &= 32'hFFF;
  endfunction

  // register writes, prediction and comparison on each edge
  always @(posedge clk) begin
    copy_t want;
    copy_t got;
    if (rst) begin
      width_reg       = 1;
      height_reg      = 1;
      rows_factor_reg = 1;
      cols_factor_reg = 1;
      relu_on         = 1'b0;
      cap_reg         = '0;
      row_pos         = 0;
      col_pos         = 0;
      pending_copies.delete();
    end else begin
      if (cfg_write) begin
        case (reg_idx_t'(cfg_index))
          REG_IN_WIDTH:    width_reg = cfg_data[DIM_CFG_W-1:0];
          REG_IN_HEIGHT:   height_reg = cfg_data[DIM_CFG_W-1:0];
          REG_FACTOR_ROWS: rows_factor_reg = cfg_data[FACTOR_W-1:0];
          REG_FACTOR_COLS: cols_factor_reg = cfg_data[FACTOR_W-1:0];
          REG_RELU_ENABLE: relu_on = cfg_data[0];
          REG_RELU_CAP:    cap_reg = cfg_data[CAP_W-1:0];
          default: ;
        endcase
      end
      if (pixels.valid && pixels.ready) expand_pixel(pixels.pixel_value);
      if (copies.valid && copies.ready) begin
        got.value     = copies.out_value;
        got.row       = copies.out_row;
        got.col       = copies.out_col;
        got.last_copy = copies.last_copy;
        if (pending_copies.size() == 0) begin
          errors++;
          if (reports++ < REPORT_MAX)
            $display("%0t: unexpected word: value %0d row %0d col %0d last %0b",
                     $time, got.value, got.row, got.col, got.last_copy);
        end else begin
          want = pending_copies.pop_front();
          if (got.value !== want.value || got.row !== want.row ||
              got.col !== want.col || got.last_copy !== want.last_copy) begin
            errors++;
            if (reports++ < REPORT_MAX)
              $display("%0t: word mismatch: expected value %0d row %0d col %0d last %0b, got value %0d row %0d col %0d last %0b",
                       $time, want.value, want.row, want.col, want.last_copy,
                       got.value, got.row, got.col, got.last_copy);
          end
        end
      end
    end
    outstanding <= pending_copies.size();
  end

endmodule

// ===== tb/nearest_upsample_relu_test.sv =====
// stimulus and verdict for the nearest-neighbor upsampler
// depends on nur_pkg, nur_if, nearest_upsample_relu and nur_upsample_checker
`timescale 1ns / 1ps

module nearest_upsample_relu_test;
  import nur_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_LEN     = 300;
  localparam int RANDOM_ITEMS = 250;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  sink_ready = 1'b0;

  int errors;
  int outstanding;
  int cycle_count;
  int idle_pct;
  int stall_pct = 0;
  logic hold_on = 1'b0;
  int hold_count = 0;
  int items_sent;

  nur_pixel_if pixels ();
  nur_copy_if  copies ();

  assign copies.ready = sink_ready;

  nearest_upsample_relu dut (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pixels),
    .copies    (copies),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  nur_upsample_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .pixels      (pixels),
    .copies      (copies),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stalls, or one long hold-off while hold_on is set
  always @(posedge clk) begin
    if (hold_on && hold_count < HOLD_LEN) begin
      sink_ready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      sink_ready <= ($urandom_range(0, 99) >= stall_pct);
      if (!hold_on) hold_count <= 0;
    end
  end

  // register write, one cycle of write enable
  task automatic write_reg(reg_idx_t idx, int unsigned val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_all(int unsigned w, int unsigned h, int unsigned fr,
                           int unsigned fc, int unsigned relu, int unsigned cap);
    write_reg(REG_IN_WIDTH, w);
    write_reg(REG_IN_HEIGHT, h);
    write_reg(REG_FACTOR_ROWS, fr);
    write_reg(REG_FACTOR_COLS, fc);
    write_reg(REG_RELU_ENABLE, relu);
    write_reg(REG_RELU_CAP, cap);
  endtask

  // offer one pixel word after a random gap, return once accepted
  task automatic send_pixel(logic [VALUE_W-1:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      pixels.valid <= 1'b0;
      @(posedge clk);
    end
    pixels.valid       <= 1'b1;
    pixels.pixel_value <= v;
    do @(posedge clk); while (!pixels.ready);
    items_sent++;
  endtask

  // stop offering and wait until every predicted copy has come out
  task automatic wait_drained();
    pixels.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 4096;
      2: return 8191;
      3: return $urandom_range(0, 8191);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic int unsigned pick_factor();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 8;
      2: return 15;
      3: return $urandom_range(0, 15);
      default: return $urandom_range(1, 3);
    endcase
  endfunction

  function automatic int unsigned pick_cap();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 32767;
      2: return $urandom_range(0, 32767);
      default: return $urandom_range(1, 1024);
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return VALUE_W'(int'($urandom_range(0, 2048)) - 1024);
      default: return VALUE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // stimulus
  initial begin
    int n;
    int mode;
    rst                = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    pixels.valid       = 1'b0;
    pixels.pixel_value = '0;
    idle_pct           = 0;
    items_sent         = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset: 1x1, no rectification
    send_pixel(16'h8000);
    send_pixel(16'h7FFF);
    wait_drained();

    // full 3x2 plane at 2x3 with relu, then wrap into the next plane
    write_all(3, 2, 2, 3, 1, 0);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    send_pixel(16'h7FFF);
    send_pixel(16'h8000);
    send_pixel(16'h0001);
    send_pixel(16'h0100);
    send_pixel(16'h0042);
    wait_drained();

    // cap at 384: equal, just above, max
    write_all(5, 3, 1, 2, 1, 16'h0180);
    send_pixel(16'h0180);
    send_pixel(16'h0181);
    send_pixel(16'h7FFF);
    wait_drained();

    // shrink mid-plane, zero and oversized factors, cap with relu off
    write_all(2, 1, 0, 15, 0, 100);
    send_pixel(16'h8000);
    send_pixel(16'h1234);
    wait_drained();

    // zero dimensions, largest factors
    write_all(0, 0, 8, 8, 1, 32767);
    send_pixel(16'h5A5A);
    wait_drained();

    // width above the maximum, height at the maximum
    write_all(8191, 4096, 1, 1, 0, 0);
    send_pixel(16'hA5A5);
    send_pixel(16'h7FFF);
    wait_drained();

    // random phases cycling through the idle and stall modes
    n = 0;
    mode = 0;
    while (n < RANDOM_ITEMS) begin
      write_all(pick_dim(), pick_dim(), pick_factor(), pick_factor(),
                $urandom_range(0, 1), pick_cap());
      case (mode % 5)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 80; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 80; end
        3: begin idle_pct = 28; stall_pct <= 28; end
        default: begin idle_pct = 0; stall_pct <= 0; hold_on <= 1'b1; end
      endcase
      repeat ($urandom_range(8, 30)) begin
        send_pixel(pick_pixel());
        n++;
      end
      wait_drained();
      hold_on <= 1'b0;
      mode++;
    end

    // let any stray word show up
    stall_pct <= 0;
    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
